### src/pfos_pkg.sv
// Package for the follower time offset unit: codes, beat types and the offset arithmetic.
`timescale 1ns / 1ps
`default_nettype none
package pfos_pkg;

	localparam int unsigned TimeWidth = 32;
	localparam logic [TimeWidth-1:0] OwnSerialReset = '0;

	localparam logic [7:0] FLAG_SYNC     = 8'd0;
	localparam logic [7:0] FLAG_REQUEST  = 8'd1;
	localparam logic [7:0] FLAG_RESPONSE = 8'd2;
	localparam logic [7:0] FLAG_RELEASE  = 8'd4;
	localparam logic [7:0] FLAG_NONE     = 8'd0;

	typedef enum logic [1:0] {
		KIND_PACKET  = 2'd0,
		KIND_DEPART  = 2'd1,
		KIND_RESTART = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ACT_SEND_REQ  = 2'd0,
		ACT_OFFSET    = 2'd1,
		ACT_COMPLETE  = 2'd2
	} action_t;

	typedef enum logic [2:0] {
		PH_WAIT_SYNC    = 3'd0,
		PH_WAIT_DEPART  = 3'd1,
		PH_WAIT_RESP    = 3'd2,
		PH_WAIT_UNBLOCK = 3'd3,
		PH_DONE         = 3'd4
	} phase_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [7:0]  packet_flag;
		logic [31:0] packet_serial;
		logic [31:0] packet_time;
		logic [31:0] local_time;
	} evt_t;

	typedef struct packed {
		logic [1:0]         action;
		logic [7:0]         send_flag;
		logic [31:0]        send_serial;
		logic signed [31:0] clock_offset;
		logic [31:0]        release_time;
		logic signed [31:0] wait_ticks;
	} res_t;

	// Negated half of the summed path differences, truncated towards zero and saturated.
	function automatic logic [31:0] offset_calc(
		input logic [31:0] arrival,
		input logic [31:0] sent,
		input logic [31:0] departed,
		input logic [31:0] remote
	);
		logic [31:0] d1;
		logic [31:0] d2;
		logic [32:0] sum;
		logic [32:0] biased;
		logic [32:0] half;
		logic [32:0] neg;
		logic [31:0] res;
		d1     = arrival - sent;
		d2     = departed - remote;
		sum    = {d1[31], d1} + {d2[31], d2};
		biased = sum + {32'd0, sum[32]};
		half   = {biased[32], biased[32:1]};
		neg    = ~half + 33'd1;
		if (neg == 33'h0_8000_0000) begin
			res = 32'h7FFF_FFFF;
		end else begin
			res = neg[31:0];
		end
		return res;
	endfunction

endpackage
`default_nettype wire

### src/pfos_ifs.sv
// Valid/ready channel interfaces for event beats and result beats.
`timescale 1ns / 1ps
`default_nettype none
interface pfos_evt_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  packet_flag;
	logic [31:0] packet_serial;
	logic [31:0] packet_time;
	logic [31:0] local_time;

	modport source (output valid, kind, packet_flag, packet_serial, packet_time, local_time,
		input ready);
	modport sink (input valid, kind, packet_flag, packet_serial, packet_time, local_time,
		output ready);
endinterface

interface pfos_res_if;
	logic               valid;
	logic               ready;
	logic [1:0]         action;
	logic [7:0]         send_flag;
	logic [31:0]        send_serial;
	logic signed [31:0] clock_offset;
	logic [31:0]        release_time;
	logic signed [31:0] wait_ticks;

	modport source (output valid, action, send_flag, send_serial, clock_offset, release_time,
		wait_ticks, input ready);
	modport sink (input valid, action, send_flag, send_serial, clock_offset, release_time,
		wait_ticks, output ready);
endinterface
`default_nettype wire

### src/pfos_in_reg.sv
// Input register that captures one event beat ahead of the protocol logic.
`timescale 1ns / 1ps
`default_nettype none
module pfos_in_reg (
	input  wire logic           clk,
	input  wire logic           arst_n,
	pfos_evt_if.sink            events,
	input  wire logic           advance,
	output logic                valid_s1,
	output pfos_pkg::evt_t      item_s1
);
	logic take;

	assign events.ready = !valid_s1 || advance;
	assign take         = events.valid && events.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (events.ready) begin
			valid_s1 <= events.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			item_s1 <= '{kind: events.kind, packet_flag: events.packet_flag,
				packet_serial: events.packet_serial, packet_time: events.packet_time,
				local_time: events.local_time};
		end
	end
endmodule
`default_nettype wire

### src/pfos_core.sv
// Protocol state, stored timestamps and result formation for one registered event.
`timescale 1ns / 1ps
`default_nettype none
module pfos_core (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_wr_en,
	input  wire logic [31:0]       cfg_wr_data,
	input  wire logic              advance,
	input  wire pfos_pkg::evt_t    item,
	output logic                   res_valid,
	output pfos_pkg::res_t         res
);
	logic [31:0]      own_serial_q;
	pfos_pkg::phase_t phase_q, phase_d;
	logic [31:0]      send_time_q, send_time_d;
	logic [31:0]      arrival_q, arrival_d;
	logic [31:0]      depart_q, depart_d;
	logic [31:0]      offset_q, offset_d;
	logic [31:0]      release_q, release_d;
	logic             seen_q, seen_d;
	logic             to_us;

	assign to_us = item.packet_serial == own_serial_q;

	always_comb begin
		phase_d     = phase_q;
		send_time_d = send_time_q;
		arrival_d   = arrival_q;
		depart_d    = depart_q;
		offset_d    = offset_q;
		release_d   = release_q;
		seen_d      = seen_q;
		res_valid   = 1'b0;
		res         = '0;
		case (item.kind)
			pfos_pkg::KIND_RESTART: begin
				phase_d = pfos_pkg::PH_WAIT_SYNC;
				seen_d  = 1'b0;
			end
			pfos_pkg::KIND_DEPART: begin
				if (phase_q == pfos_pkg::PH_WAIT_DEPART) begin
					depart_d = item.local_time;
					phase_d  = pfos_pkg::PH_WAIT_RESP;
				end
			end
			pfos_pkg::KIND_PACKET: begin
				if (phase_q != pfos_pkg::PH_DONE) begin
					if (item.packet_flag == pfos_pkg::FLAG_SYNC && to_us) begin
						if (phase_q inside {pfos_pkg::PH_WAIT_SYNC, pfos_pkg::PH_WAIT_DEPART,
							pfos_pkg::PH_WAIT_RESP}) begin
							send_time_d = item.packet_time;
							arrival_d   = item.local_time;
							if (phase_q == pfos_pkg::PH_WAIT_SYNC) begin
								phase_d         = pfos_pkg::PH_WAIT_DEPART;
								res_valid       = 1'b1;
								res.action      = pfos_pkg::ACT_SEND_REQ;
								res.send_flag   = pfos_pkg::FLAG_REQUEST;
								res.send_serial = own_serial_q;
							end
						end
					end else if (item.packet_flag == pfos_pkg::FLAG_RELEASE) begin
						release_d = item.packet_time;
						seen_d    = 1'b1;
						if (phase_q == pfos_pkg::PH_WAIT_UNBLOCK) begin
							phase_d          = pfos_pkg::PH_DONE;
							res_valid        = 1'b1;
							res.action       = pfos_pkg::ACT_COMPLETE;
							res.clock_offset = offset_q;
							res.release_time = item.packet_time;
							res.wait_ticks   = item.packet_time - (item.local_time + offset_q);
						end
					end else if (item.packet_flag == pfos_pkg::FLAG_RESPONSE && to_us) begin
						if (phase_q == pfos_pkg::PH_WAIT_RESP) begin
							offset_d = pfos_pkg::offset_calc(arrival_q, send_time_q, depart_q,
								item.packet_time);
							res_valid        = 1'b1;
							res.clock_offset = offset_d;
							if (seen_q) begin
								phase_d          = pfos_pkg::PH_DONE;
								res.action       = pfos_pkg::ACT_COMPLETE;
								res.release_time = release_q;
								res.wait_ticks   = release_q - (item.local_time + offset_d);
							end else begin
								phase_d    = pfos_pkg::PH_WAIT_UNBLOCK;
								res.action = pfos_pkg::ACT_OFFSET;
							end
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			own_serial_q <= pfos_pkg::OwnSerialReset;
			phase_q      <= pfos_pkg::PH_WAIT_SYNC;
			send_time_q  <= '0;
			arrival_q    <= '0;
			depart_q     <= '0;
			offset_q     <= '0;
			release_q    <= '0;
			seen_q       <= 1'b0;
		end else begin
			if (cfg_wr_en) begin
				own_serial_q <= cfg_wr_data;
			end
			if (advance) begin
				phase_q     <= phase_d;
				send_time_q <= send_time_d;
				arrival_q   <= arrival_d;
				depart_q    <= depart_d;
				offset_q    <= offset_d;
				release_q   <= release_d;
				seen_q      <= seen_d;
			end
		end
	end
endmodule
`default_nettype wire

### src/pfos_out_reg.sv
// Result register that holds one result beat until the consumer takes it.
`timescale 1ns / 1ps
`default_nettype none
module pfos_out_reg (
	input  wire logic            clk,
	input  wire logic            arst_n,
	pfos_res_if.source           results,
	input  wire logic            advance,
	input  wire logic            res_valid,
	input  wire pfos_pkg::res_t  res,
	output logic                 slot_free
);
	logic           valid_q;
	pfos_pkg::res_t res_q;

	assign slot_free = !valid_q || results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (slot_free) begin
			valid_q <= advance && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free && advance && res_valid) begin
			res_q <= res;
		end
	end

	assign results.valid        = valid_q;
	assign results.action       = res_q.action;
	assign results.send_flag    = res_q.send_flag;
	assign results.send_serial  = res_q.send_serial;
	assign results.clock_offset = res_q.clock_offset;
	assign results.release_time = res_q.release_time;
	assign results.wait_ticks   = res_q.wait_ticks;
endmodule
`default_nettype wire

### src/ptp_follower_offset_sync_unit.sv
// Top level of the follower time offset unit.
// The unit takes one event beat per clock cycle and returns at most one result beat for it.
// An accepted event is registered in the input register and evaluated against the protocol state
// once it advances; its result, if any, is loaded into the result register at that point and
// offered from there. The sustained rate is one event per cycle; it drops only while the
// result register holds a beat that the consumer has not taken. The own serial number may
// be written only while no event is in flight.
`timescale 1ns / 1ps
`default_nettype none
module ptp_follower_offset_sync_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_wr_en,
	input  wire logic [31:0] cfg_wr_data,
	pfos_evt_if.sink         events,
	pfos_res_if.source       results
);
	logic            valid_s1;
	pfos_pkg::evt_t  item_s1;
	logic            slot_free;
	logic            advance;
	logic            res_valid;
	pfos_pkg::res_t  res;

	assign advance = valid_s1 && slot_free;

	pfos_in_reg u_in_reg (
		.clk      (clk),
		.arst_n   (arst_n),
		.events   (events),
		.advance  (advance),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	pfos_core u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.advance     (advance),
		.item        (item_s1),
		.res_valid   (res_valid),
		.res         (res)
	);

	pfos_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.results   (results),
		.advance   (advance),
		.res_valid (res_valid),
		.res       (res),
		.slot_free (slot_free)
	);
endmodule
`default_nettype wire
